FILE: design/brfl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brfl_pkg
// Command and status codes shared by the byte ring fifo with lookahead.
// ----------------------------------------------------------------------------
package brfl_pkg;

  // command codes
  typedef logic [2:0] kind_t;
  localparam kind_t KIND_PUT        = 3'd0;
  localparam kind_t KIND_PUTBACK    = 3'd1;
  localparam kind_t KIND_GET        = 3'd2;
  localparam kind_t KIND_CLEAR      = 3'd3;
  localparam kind_t KIND_CUR_RESET  = 3'd4;
  localparam kind_t KIND_CUR_END    = 3'd5;
  localparam kind_t KIND_CUR_GET    = 3'd6;
  localparam kind_t KIND_CONSUME    = 3'd7;

  // result status codes
  typedef logic [1:0] status_t;
  localparam status_t STAT_OK    = 2'd0;
  localparam status_t STAT_FULL  = 2'd1;
  localparam status_t STAT_EMPTY = 2'd2;

  typedef logic [7:0] byte_t;

endpackage
`default_nettype wire

FILE: design/byte_ring_fifo_with_lookahead.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// byte_ring_fifo_with_lookahead
// Byte ring fifo with putback, clear and one read-ahead cursor.
//
//   channel   ports                                          beat taken when
//   command   start busy kind data_byte                      start & !busy
//   result    done status read_byte is_empty free_space      done
//             cursor_done
//
// A command is taken at its accepting edge: pointers update there and the
// result beat follows in the next cycle, with registered read data from the
// byte store. A new command may be issued every cycle; busy stays low. Writes
// and reads of the store happen at different edges, so a read always sees
// the previous command's write. Reset (rst, synchronous) empties the fifo and
// parks the cursor at its end; the store is not cleared. The receiver cannot
// stall: each result is shown for one cycle.
// ----------------------------------------------------------------------------
module byte_ring_fifo_with_lookahead #(
  parameter int DEPTH = 256
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  output      logic                       busy,
  input  wire brfl_pkg::kind_t            kind,
  input  wire brfl_pkg::byte_t            data_byte,
  output      logic                       done,
  output      brfl_pkg::status_t          status,
  output      brfl_pkg::byte_t            read_byte,
  output      logic                       is_empty,
  output      logic [$clog2(DEPTH+1)-1:0] free_space,
  output      logic                       cursor_done
);
  import brfl_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int FW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [FW-1:0] DEPTH_F = FW'(DEPTH);

  // pointer state
  logic [PW-1:0] head_ptr, head_ptr_next;
  logic [PW-1:0] tail_ptr, tail_ptr_next;
  logic [PW-1:0] peek_ptr, peek_ptr_next;
  logic          full_flag, full_flag_next;
  logic          peek_done, peek_done_next;

  // store access
  logic          mem_we, mem_re;
  logic [PW-1:0] mem_waddr, mem_raddr;
  byte_t         mem_q;

  // result registers
  status_t       status_next;
  logic          rd_ok, rd_ok_next;
  logic          accept;

  logic [PW-1:0] head_inc, head_dec, tail_inc, peek_inc;
  logic          cur_empty;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  assign head_inc  = (head_ptr == LAST) ? '0 : head_ptr + 1'b1;
  assign head_dec  = (head_ptr == '0) ? LAST : head_ptr - 1'b1;
  assign tail_inc  = (tail_ptr == LAST) ? '0 : tail_ptr + 1'b1;
  assign peek_inc  = (peek_ptr == LAST) ? '0 : peek_ptr + 1'b1;
  assign cur_empty = (head_ptr == tail_ptr) & ~full_flag;

  // command decode and next pointer state
  always_comb begin
    head_ptr_next  = head_ptr;
    tail_ptr_next  = tail_ptr;
    peek_ptr_next  = peek_ptr;
    full_flag_next = full_flag;
    peek_done_next = peek_done;
    status_next    = STAT_OK;
    rd_ok_next     = 1'b0;
    mem_we         = 1'b0;
    mem_waddr      = tail_ptr;
    mem_re         = 1'b0;
    mem_raddr      = head_ptr;
    unique case (kind)
      KIND_PUT: begin
        if (full_flag) begin
          status_next = STAT_FULL;
        end else begin
          mem_we        = 1'b1;
          tail_ptr_next = tail_inc;
          if (head_ptr == tail_inc) full_flag_next = 1'b1;
        end
      end
      KIND_PUTBACK: begin
        if (full_flag) begin
          status_next = STAT_FULL;
        end else begin
          mem_we        = 1'b1;
          mem_waddr     = head_dec;
          head_ptr_next = head_dec;
          if (head_dec == tail_ptr) full_flag_next = 1'b1;
        end
      end
      KIND_GET: begin
        if (cur_empty) begin
          status_next = STAT_EMPTY;
        end else begin
          mem_re         = 1'b1;
          rd_ok_next     = 1'b1;
          full_flag_next = 1'b0;
          head_ptr_next  = head_inc;
        end
      end
      KIND_CLEAR: begin
        head_ptr_next  = tail_ptr;
        full_flag_next = 1'b0;
      end
      KIND_CUR_RESET: begin
        if (cur_empty) begin
          peek_done_next = 1'b1;
        end else begin
          peek_ptr_next  = head_ptr;
          peek_done_next = 1'b0;
        end
      end
      KIND_CUR_END: begin
        peek_done_next = 1'b1;
      end
      KIND_CUR_GET: begin
        if (peek_done) begin
          status_next = STAT_EMPTY;
        end else begin
          mem_re        = 1'b1;
          mem_raddr     = peek_ptr;
          rd_ok_next    = 1'b1;
          peek_ptr_next = peek_inc;
          if (peek_inc == tail_ptr) peek_done_next = 1'b1;
        end
      end
      KIND_CONSUME: begin
        if (peek_done) begin
          head_ptr_next  = tail_ptr;
          full_flag_next = 1'b0;
        end else if (peek_ptr != head_ptr) begin
          head_ptr_next  = peek_ptr;
          full_flag_next = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  // pointer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      head_ptr  <= '0;
      tail_ptr  <= '0;
      peek_ptr  <= '0;
      full_flag <= 1'b0;
      peek_done <= 1'b1;
    end else if (accept) begin
      head_ptr  <= head_ptr_next;
      tail_ptr  <= tail_ptr_next;
      peek_ptr  <= peek_ptr_next;
      full_flag <= full_flag_next;
      peek_done <= peek_done_next;
    end
  end

  // byte store
  brfl_ram #(
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (accept & mem_we),
    .waddr(mem_waddr),
    .wdata(data_byte),
    .re   (accept & mem_re),
    .raddr(mem_raddr),
    .rdata(mem_q)
  );

  // result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= accept;
    end
  end

  // result payload, taken from the state after the command
  always_ff @(posedge clk) begin
    if (accept) begin
      status      <= status_next;
      rd_ok       <= rd_ok_next;
      is_empty    <= (head_ptr_next == tail_ptr_next) & ~full_flag_next;
      cursor_done <= peek_done_next;
      if (full_flag_next) begin
        free_space <= '0;
      end else if (tail_ptr_next >= head_ptr_next) begin
        free_space <= DEPTH_F - FW'(tail_ptr_next) + FW'(head_ptr_next);
      end else begin
        free_space <= FW'(head_ptr_next) - FW'(tail_ptr_next);
      end
    end
  end

  // read data is zero unless a read succeeded
  assign read_byte = rd_ok ? mem_q : '0;

endmodule
`default_nettype wire

FILE: design/brfl_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brfl_ram
// Byte store: one write port and one read port, registered read data.
// ----------------------------------------------------------------------------
module brfl_ram #(
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire brfl_pkg::byte_t          wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      brfl_pkg::byte_t          rdata
);
  import brfl_pkg::*;

  byte_t mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

FILE: verif/brfl_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brfl_checker
// Watches the command and result channels of the byte ring fifo, keeps its
// own copy of the fifo pointers, cursor and byte store, works out the result
// of each accepted command and compares every result beat field by field.
// ----------------------------------------------------------------------------
module brfl_checker
  import brfl_pkg::*;
#(
  parameter int DEPTH = 256,
  parameter int FW    = $clog2(DEPTH + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic          busy,
  input  kind_t         kind,
  input  byte_t         data_byte,
  input  logic          done,
  input  status_t       status,
  input  byte_t         read_byte,
  input  logic          is_empty,
  input  logic [FW-1:0] free_space,
  input  logic          cursor_done,
  output int            fail_count,
  output int            pending
);

  localparam int PW = $clog2(DEPTH);

  typedef struct {
    status_t       stat;
    byte_t         rd;
    logic          empty;
    logic [FW-1:0] space;
    logic          at_end;
  } cmd_result_t;

  // shadow fifo state
  byte_t         shadow_mem [DEPTH];
  logic [PW-1:0] rd_slot;
  logic [PW-1:0] wr_slot;
  logic          is_full;
  logic [PW-1:0] look_slot;
  logic          look_end;

  cmd_result_t   result_q [$];
  int            errors;

  assign fail_count = errors;

  function automatic logic [PW-1:0] step_slot(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic fifo_empty();
    return (rd_slot == wr_slot) && !is_full;
  endfunction

  // apply one command to the shadow state and return the result it gives
  function automatic cmd_result_t apply_command(input kind_t k, input byte_t d);
    cmd_result_t   r;
    logic [PW-1:0] gap;
    r.stat = STAT_OK;
    r.rd   = '0;
    case (k)
      KIND_PUT: begin
        if (is_full) begin
          r.stat = STAT_FULL;
        end else begin
          shadow_mem[wr_slot] = d;
          wr_slot = step_slot(wr_slot);
          if (rd_slot == wr_slot) is_full = 1'b1;
        end
      end
      KIND_PUTBACK: begin
        if (is_full) begin
          r.stat = STAT_FULL;
        end else begin
          rd_slot = (rd_slot == '0) ? PW'(DEPTH - 1) : rd_slot - 1'b1;
          shadow_mem[rd_slot] = d;
          if (rd_slot == wr_slot) is_full = 1'b1;
        end
      end
      KIND_GET: begin
        if (fifo_empty()) begin
          r.stat = STAT_EMPTY;
        end else begin
          is_full = 1'b0;
          r.rd    = shadow_mem[rd_slot];
          rd_slot = step_slot(rd_slot);
        end
      end
      KIND_CLEAR: begin
        rd_slot = wr_slot;
        is_full = 1'b0;
      end
      KIND_CUR_RESET: begin
        if (fifo_empty()) begin
          look_end = 1'b1;
        end else begin
          look_slot = rd_slot;
          look_end  = 1'b0;
        end
      end
      KIND_CUR_END: begin
        look_end = 1'b1;
      end
      KIND_CUR_GET: begin
        if (look_end) begin
          r.stat = STAT_EMPTY;
        end else begin
          r.rd      = shadow_mem[look_slot];
          look_slot = step_slot(look_slot);
          if (look_slot == wr_slot) look_end = 1'b1;
        end
      end
      default: begin
        // consume: drop what the cursor passed, or everything at its end
        if (look_end) begin
          rd_slot = wr_slot;
          is_full = 1'b0;
        end else if (look_slot != rd_slot) begin
          rd_slot = look_slot;
          is_full = 1'b0;
        end
      end
    endcase
    gap      = rd_slot - wr_slot;
    r.empty  = fifo_empty();
    r.space  = is_full ? '0 : (gap == '0) ? FW'(DEPTH) : FW'(gap);
    r.at_end = look_end;
    return r;
  endfunction

  // result beats are checked before the command beat of the same edge
  always @(posedge clk) begin : watch
    cmd_result_t want;
    if (rst) begin
      rd_slot   = '0;
      wr_slot   = '0;
      is_full   = 1'b0;
      look_slot = '0;
      look_end  = 1'b1;
      result_q.delete();
      errors    = 0;
      pending  <= 0;
    end else begin
      if (done) begin
        if (result_q.size() == 0) begin
          $error("result beat with no command outstanding");
          errors++;
        end else begin
          want = result_q.pop_front();
          if (status !== want.stat) begin
            $error("status: expected %0d, got %0d", want.stat, status);
            errors++;
          end
          if (read_byte !== want.rd) begin
            $error("read_byte: expected %0h, got %0h", want.rd, read_byte);
            errors++;
          end
          if (is_empty !== want.empty) begin
            $error("is_empty: expected %0d, got %0d", want.empty, is_empty);
            errors++;
          end
          if (free_space !== want.space) begin
            $error("free_space: expected %0d, got %0d", want.space, free_space);
            errors++;
          end
          if (cursor_done !== want.at_end) begin
            $error("cursor_done: expected %0d, got %0d", want.at_end, cursor_done);
            errors++;
          end
        end
      end
      if (start && !busy) result_q.push_back(apply_command(kind, data_byte));
      pending <= result_q.size();
    end
  end

endmodule

FILE: verif/byte_ring_fifo_with_lookahead_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_ring_fifo_with_lookahead_test
// Drives commands into the byte ring fifo: a full fill and drain that writes
// every slot, a directed pass over putback, clear, consume and the cursor,
// then random phases biased toward filling, draining or cursor walks, with
// random gaps between beats. The checker beside the block does the scoring.
// ----------------------------------------------------------------------------
module byte_ring_fifo_with_lookahead_test;
  import brfl_pkg::*;

  localparam int DEPTH       = 256;
  localparam int FW          = $clog2(DEPTH + 1);
  localparam int RAND_ITEMS  = 1000;
  localparam int SETTLE_CYC  = 5;

  typedef enum int {MODE_FILL, MODE_DRAIN, MODE_CURSOR, MODE_MIXED} phase_mode_t;

  logic          clk;
  logic          rst       = 1'b1;
  logic          start     = 1'b0;
  kind_t         kind      = KIND_PUT;
  byte_t         data_byte = '0;
  logic          busy;
  logic          done;
  status_t       status;
  byte_t         read_byte;
  logic          is_empty;
  logic [FW-1:0] free_space;
  logic          cursor_done;
  int            fail_count;
  int            pending;

  logic          quiet     = 1'b0;
  int            rand_sent = 0;

  byte_ring_fifo_with_lookahead #(.DEPTH(DEPTH)) u_top (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .kind        (kind),
    .data_byte   (data_byte),
    .done        (done),
    .status      (status),
    .read_byte   (read_byte),
    .is_empty    (is_empty),
    .free_space  (free_space),
    .cursor_done (cursor_done)
  );

  brfl_checker #(.DEPTH(DEPTH)) u_check (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .kind        (kind),
    .data_byte   (data_byte),
    .done        (done),
    .status      (status),
    .read_byte   (read_byte),
    .is_empty    (is_empty),
    .free_space  (free_space),
    .cursor_done (cursor_done),
    .fail_count  (fail_count),
    .pending     (pending)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // run limit
  initial begin
    #10ms;
    $display("Regression FAIL");
    $finish;
  end

  // mostly back to back, some short gaps, a few long ones
  function automatic int gap_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  // one command beat, then an optional idle gap
  task automatic send_cmd(input kind_t k, input byte_t d);
    int n;
    start     <= 1'b1;
    kind      <= k;
    data_byte <= d;
    do @(posedge clk); while (busy);
    n = gap_cycles();
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // hold off until every outstanding result beat has come back
  task automatic wait_idle();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  function automatic kind_t pick_kind(input phase_mode_t mode);
    int r;
    r = $urandom_range(0, 99);
    case (mode)
      MODE_FILL: begin
        if (r < 70) return KIND_PUT;
        if (r < 85) return KIND_PUTBACK;
        return kind_t'($urandom_range(2, 7));
      end
      MODE_DRAIN: begin
        if (r < 50) return KIND_GET;
        if (r < 65) return KIND_CONSUME;
        if (r < 80) return KIND_CUR_GET;
        return kind_t'($urandom_range(0, 7));
      end
      MODE_CURSOR: begin
        if (r < 15) return KIND_CUR_RESET;
        if (r < 65) return KIND_CUR_GET;
        if (r < 80) return KIND_CONSUME;
        if (r < 90) return KIND_PUT;
        return kind_t'($urandom_range(0, 7));
      end
      default: return kind_t'($urandom_range(0, 7));
    endcase
  endfunction

  // stimulus
  initial begin
    phase_mode_t mode;
    int          len;
    int          phase_no;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // fill to one short of full, then let putback close the ring
    for (int i = 0; i < DEPTH - 1; i++) send_cmd(KIND_PUT, byte_t'(i));
    send_cmd(KIND_PUTBACK, 8'hEE);
    send_cmd(KIND_PUT, 8'h11);
    send_cmd(KIND_PUTBACK, 8'h22);
    send_cmd(KIND_CUR_RESET, '0);
    send_cmd(KIND_CUR_GET, '0);
    send_cmd(KIND_CUR_GET, '0);
    for (int i = 0; i < DEPTH; i++) send_cmd(KIND_GET, '0);
    send_cmd(KIND_GET, '0);

    // directed corners, every slot now holds a written byte
    send_cmd(KIND_CUR_GET, '0);
    send_cmd(KIND_PUT, 8'h00);
    send_cmd(KIND_PUT, 8'hFF);
    send_cmd(KIND_PUTBACK, 8'hA5);
    send_cmd(KIND_CUR_RESET, '0);
    send_cmd(KIND_CONSUME, '0);
    send_cmd(KIND_CUR_GET, '0);
    send_cmd(KIND_CUR_GET, '0);
    send_cmd(KIND_CONSUME, '0);
    send_cmd(KIND_CUR_GET, '0);
    send_cmd(KIND_CUR_GET, '0);
    send_cmd(KIND_PUT, 8'h5A);
    send_cmd(KIND_CUR_END, '0);
    send_cmd(KIND_CONSUME, '0);
    send_cmd(KIND_GET, '0);
    send_cmd(KIND_CUR_RESET, '0);
    send_cmd(KIND_PUTBACK, 8'h3C);
    send_cmd(KIND_PUT, 8'hC3);
    send_cmd(KIND_CUR_RESET, '0);
    send_cmd(KIND_GET, '0);
    send_cmd(KIND_CLEAR, '0);
    send_cmd(KIND_CUR_GET, '0);
    send_cmd(KIND_PUTBACK, 8'h81);
    send_cmd(KIND_CUR_GET, '0);
    send_cmd(KIND_CONSUME, '0);
    send_cmd(KIND_CLEAR, '0);
    wait_idle();

    // random phases, most with a bias per phase
    phase_no = 0;
    while (rand_sent < RAND_ITEMS) begin
      mode  = phase_mode_t'($urandom_range(0, 3));
      len   = $urandom_range(20, 300);
      quiet = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < len; i++) begin
        send_cmd(pick_kind(mode), byte_t'($urandom_range(0, 255)));
        rand_sent++;
      end
      phase_no++;
      if (phase_no % 5 == 0) wait_idle();
    end

    wait_idle();
    repeat (SETTLE_CYC) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
